// File: hw/rtl/vma_pkg.sv
// ----------------------------------------------------------------------------
// Vector moving average package
// Shared constants and the operation code used by the front and back parts.
// ----------------------------------------------------------------------------
package vma_pkg;

  // Default sizing of the averaging ring and of one sample.
  localparam int MAX_CELLS_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 32;

  // Width of the window length register as written by software.
  localparam int CFG_BITS = 11;

  // Number of vector components handled side by side.
  localparam int LANES = 3;

  // Depth of the queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;

  // Operation decoded from the mode field of a request.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_FILL = 1'b1
  } op_t;

endpackage

// File: hw/rtl/vma_if.sv
// ----------------------------------------------------------------------------
// Vector moving average channels
// Valid/ready channels for input samples and for output means.
// ----------------------------------------------------------------------------
interface vma_sample_if import vma_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, mode, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, mode, sample_x, sample_y, sample_z, output ready);
endinterface

interface vma_mean_if import vma_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean_x;
  logic signed [SAMPLE_BITS-1:0] mean_y;
  logic signed [SAMPLE_BITS-1:0] mean_z;

  modport source (output valid, mean_x, mean_y, mean_z, input ready);
  modport sink   (input valid, mean_x, mean_y, mean_z, output ready);
endinterface

// File: hw/rtl/vma_ram.sv
// ----------------------------------------------------------------------------
// Vector moving average RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module vma_ram import vma_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/vma_fifo.sv
// ----------------------------------------------------------------------------
// Vector moving average queue
// Small register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module vma_fifo import vma_pkg::*; #(
  parameter int WIDTH = 97,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Storage is payload only.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/vma_front.sv
// ----------------------------------------------------------------------------
// Vector moving average front part
// Accepts sample requests, decodes the operation and stages them for the queue.
// ----------------------------------------------------------------------------
module vma_front import vma_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  vma_sample_if.sink                          samples,
  output logic                                push_valid,
  input  logic                                push_ready,
  output logic [LANES*SAMPLE_BITS:0]          push_data
);

  logic                         stage_valid;
  logic [LANES*SAMPLE_BITS:0]   stage;
  logic                         accept;
  op_t                          op;

  // The stage frees up in the same cycle the queue takes its content.
  assign samples.ready = !stage_valid || push_ready;
  assign accept        = samples.valid && samples.ready;
  assign push_valid    = stage_valid;
  assign push_data     = stage;

  // Decode the mode field into an operation.
  always_comb begin
    unique case (samples.mode)
      1'b1:    op = OP_FILL;
      default: op = OP_PUSH;
    endcase
  end

  // Staging register: operation over the three lanes, lane x in the low bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
    if (accept) begin
      stage <= {op, samples.sample_z, samples.sample_y, samples.sample_x};
    end
  end

endmodule

// File: hw/rtl/vma_div.sv
// ----------------------------------------------------------------------------
// Vector moving average divider
// Bit-serial restoring division of a signed sum by the window length,
// truncated toward zero.
// ----------------------------------------------------------------------------
module vma_div import vma_pkg::*; #(
  parameter int SUM_BITS = 42,
  parameter int LEN_W    = 11,
  parameter int Q_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SUM_BITS-1:0] dividend,
  input  logic [LEN_W-1:0]           divisor,
  output logic                       done,
  output logic signed [Q_BITS-1:0]   quotient
);

  localparam int CNT_W = $clog2(SUM_BITS);

  typedef enum logic [1:0] {
    D_IDLE,
    D_PREP,
    D_RUN,
    D_FIX
  } dstate_t;

  dstate_t           state;
  logic [SUM_BITS-1:0] num;
  logic [LEN_W-1:0]    rem;
  logic [LEN_W-1:0]    den;
  logic [CNT_W-1:0]    cnt;
  logic                neg;
  logic [LEN_W:0]      trial;
  logic [LEN_W:0]      diff;
  logic                ge;
  logic [SUM_BITS-1:0] q_full;

  // One quotient bit per cycle.
  assign trial  = {rem, num[SUM_BITS-1]};
  assign diff   = trial - {1'b0, den};
  assign ge     = (trial >= {1'b0, den});
  assign q_full = neg ? (~num + SUM_BITS'(1)) : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      // Done pulses for one cycle, right after the quotient is stored.
      done <= (state == D_FIX);
      unique case (state)
        D_IDLE: begin
          if (start) begin
            num   <= dividend;
            den   <= divisor;
            state <= D_PREP;
          end
        end
        D_PREP: begin
          // Work on the magnitude; the sign is restored at the end.
          neg   <= num[SUM_BITS-1];
          num   <= num[SUM_BITS-1] ? (~num + SUM_BITS'(1)) : num;
          rem   <= '0;
          cnt   <= '0;
          state <= D_RUN;
        end
        D_RUN: begin
          rem   <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
          num   <= {num[SUM_BITS-2:0], ge};
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SUM_BITS - 1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          quotient <= q_full[Q_BITS-1:0];
          state    <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/vma_back.sv
// ----------------------------------------------------------------------------
// Vector moving average back part
// Updates the ring and the running sums, divides by the window length and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module vma_back import vma_pkg::*; #(
  parameter int MAX_CELLS   = MAX_CELLS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_BITS-1:0]        cfg_data,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  logic [LANES*SAMPLE_BITS:0] q_data,
  vma_mean_if.source                 means
);

  localparam int LEN_W    = $clog2(MAX_CELLS + 1);
  localparam int PTR_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_CELLS);
  localparam int ROW_W    = LANES * SAMPLE_BITS;
  localparam int PROD_W   = SAMPLE_BITS + LEN_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_DONE
  } state_t;

  state_t                        state;
  logic [LEN_W-1:0]              wlen;
  logic [LEN_W-1:0]              wlen_cfg;
  logic [PTR_W-1:0]              pos;
  logic [LEN_W-1:0]              pos_inc;
  logic                          wrapped;
  logic [LANES*SAMPLE_BITS:0]    cur;
  op_t                           cur_op;
  logic signed [SAMPLE_BITS-1:0] smp      [LANES];
  logic signed [SAMPLE_BITS-1:0] base     [LANES];
  logic signed [SAMPLE_BITS-1:0] old      [LANES];
  logic signed [SUM_BITS-1:0]    sums     [LANES];
  logic signed [SUM_BITS-1:0]    sums_next[LANES];
  logic signed [PROD_W-1:0]      prod     [LANES];
  logic signed [SAMPLE_BITS-1:0] quot     [LANES];
  logic [LANES-1:0]              div_done;
  logic                          div_start;
  logic [ROW_W-1:0]              rdata;
  logic                          ram_we;
  logic                          accept;
  logic                          out_free;

  assign q_ready   = (state == S_IDLE) && !cfg_write;
  assign accept    = q_valid && q_ready;
  assign cur_op    = op_t'(cur[ROW_W]);
  assign div_start = (state == S_UPDATE);
  assign ram_we    = (state == S_UPDATE) && (cur_op == OP_PUSH);
  assign pos_inc   = LEN_W'(pos) + LEN_W'(1);
  assign out_free  = !means.valid || means.ready;

  // Clamp the written window length into 1..MAX_CELLS.
  always_comb begin
    if (cfg_data == '0) begin
      wlen_cfg = LEN_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_CELLS)) begin
      wlen_cfg = LEN_W'(MAX_CELLS);
    end else begin
      wlen_cfg = LEN_W'(cfg_data);
    end
  end

  // Per-lane update. Cells not written since the last clear or fill read as
  // the base value, which is zero after a clear and the sample after a fill.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      smp[k]  = cur[k*SAMPLE_BITS +: SAMPLE_BITS];
      old[k]  = wrapped ? rdata[k*SAMPLE_BITS +: SAMPLE_BITS] : base[k];
      prod[k] = PROD_W'(smp[k]) * PROD_W'($signed({1'b0, wlen}));
      if (cur_op == OP_FILL) begin
        sums_next[k] = prod[k][SUM_BITS-1:0];
      end else begin
        sums_next[k] = sums[k] + SUM_BITS'(smp[k]) - SUM_BITS'(old[k]);
      end
    end
  end

  // Ring of cells, all three lanes in one row; read address follows the
  // write position so the old cell is ready when the update state reads it.
  vma_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (cur[ROW_W-1:0]),
    .raddr (pos),
    .rdata (rdata)
  );

  // One divider per lane, all started together.
  for (genvar k = 0; k < LANES; k++) begin : g_div
    vma_div #(
      .SUM_BITS (SUM_BITS),
      .LEN_W    (LEN_W),
      .Q_BITS   (SAMPLE_BITS)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (sums_next[k]),
      .divisor  (wlen),
      .done     (div_done[k]),
      .quotient (quot[k])
    );
  end

  // Sequencer, window state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wlen        <= LEN_W'(1);
      pos         <= '0;
      wrapped     <= 1'b0;
      means.valid <= 1'b0;
      for (int k = 0; k < LANES; k++) begin
        base[k] <= '0;
        sums[k] <= '0;
      end
    end else begin
      // A taken result is dropped unless a new one replaces it below.
      if (means.valid && means.ready && (state != S_DONE)) begin
        means.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_write) begin
            // A new window length empties the ring.
            wlen    <= wlen_cfg;
            pos     <= '0;
            wrapped <= 1'b0;
            for (int k = 0; k < LANES; k++) begin
              base[k] <= '0;
              sums[k] <= '0;
            end
          end else if (accept) begin
            cur   <= q_data;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          for (int k = 0; k < LANES; k++) begin
            sums[k] <= sums_next[k];
          end
          if (cur_op == OP_FILL) begin
            pos     <= '0;
            wrapped <= 1'b0;
            for (int k = 0; k < LANES; k++) begin
              base[k] <= smp[k];
            end
          end else if (pos_inc >= wlen) begin
            pos     <= '0;
            wrapped <= 1'b1;
          end else begin
            pos <= PTR_W'(pos_inc);
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (&div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            means.valid  <= 1'b1;
            means.mean_x <= quot[0];
            means.mean_y <= quot[1];
            means.mean_z <= quot[2];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/vector_moving_average.sv
// ----------------------------------------------------------------------------
// Vector moving average
// Three-lane boxcar moving average over a ring of window_length cells.
//
//   Channel    Direction  Payload                          Handshake
//   samples    in         mode, sample_x/y/z               valid/ready
//   means      out        mean_x/y/z                       valid/ready
//   cfg        in         cfg_data (window length)         cfg_write only
//
// The back part works on one request at a time: it offers the mean once all
// three dividers are done and the output register is free, and takes the
// next request only after that. The bit-serial divider, one quotient bit per
// cycle for each lane, sets the pace; a fill costs the same as a push.
// Requests pass from the input handshake through the staging register and
// the queue to the back part. They are taken into a staging register and a
// two-entry queue while the back part works, so the input stalls only when
// both are full; a mean stalled at the output holds the back part until it
// is taken. The ring is not swept on reset or on a window length write,
// since unwritten cells read as a base value; a length write acts only in idle.
// ----------------------------------------------------------------------------
module vector_moving_average import vma_pkg::*; #(
  parameter int MAX_CELLS   = MAX_CELLS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CFG_BITS-1:0] cfg_data,
  vma_sample_if.sink          samples,
  vma_mean_if.source          means
);

  localparam int ENTRY_W = LANES * SAMPLE_BITS + 1;

  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               q_valid;
  logic               q_ready;
  logic [ENTRY_W-1:0] q_data;

  // Front part: accepts and decodes requests.
  vma_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue between the two parts.
  vma_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // Back part: ring update, running sums and division.
  vma_back #(
    .MAX_CELLS   (MAX_CELLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .means     (means)
  );

endmodule

// File: hw/rtl/vma_checker.sv
// ----------------------------------------------------------------------------
// Vector moving average checker
// Port-level assertions on the result channel and on reset behavior.
// ----------------------------------------------------------------------------
module vma_checker import vma_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_x,
  input logic [SAMPLE_BITS-1:0] out_y,
  input logic [SAMPLE_BITS-1:0] out_z
);

  // No result is pending right after reset.
  a_no_result_after_reset: assert property (
    @(posedge clk) rst |=> !out_valid
  ) else $error("result offered right after reset");

  // Staging and queue are empty after reset, so requests are taken.
  a_ready_after_reset: assert property (
    @(posedge clk) rst |=> in_ready
  ) else $error("input not ready right after reset");

  // A stalled result stays offered.
  a_result_held: assert property (
    @(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid
  ) else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_result_stable: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
  ) else $error("result changed while stalled");

endmodule

bind vector_moving_average vma_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_vma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .out_valid (means.valid),
  .out_ready (means.ready),
  .out_x     (means.mean_x),
  .out_y     (means.mean_y),
  .out_z     (means.mean_z)
);

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector moving average testbench
// Drives sample requests through the valid/ready channel and writes the
// window length between phases. Every accepted request is run through a
// local three-lane boxcar predictor, and each mean that comes out is checked
// field by field against the oldest prediction. The tests cover the reset
// window, length clamping, fill and push with wrap, back-to-back traffic,
// a long output hold-off, and random windows with random samples.
// ----------------------------------------------------------------------------
module testbench;
  import vma_pkg::*;

  localparam int W = SAMPLE_BITS_DEF;

  typedef logic signed [W-1:0] lane_t;

  typedef struct packed {
    lane_t x;
    lane_t y;
    lane_t z;
  } mean_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic [CFG_BITS-1:0] cfg_data;

  vma_sample_if samples();
  vma_mean_if   means();

  vector_moving_average dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .means     (means)
  );

  // Predictor state: one ring per lane, running sums, position and length.
  lane_t  ring [LANES][MAX_CELLS_DEF];
  longint lane_total [LANES];
  int     ring_pos;
  int     ring_len;

  // Means predicted for accepted requests, oldest first.
  mean_t pending_means [$];
  int    mismatches = 0;

  // Traffic control shared by the sender, the receiver and the tests.
  bit steady = 1'b0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int stall_left = 0;

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clear the rings and sums for a new window length, clamped to the range.
  function automatic void load_window(input logic [CFG_BITS-1:0] raw);
    if (raw == 0) begin
      ring_len = 1;
    end else if (raw > MAX_CELLS_DEF) begin
      ring_len = MAX_CELLS_DEF;
    end else begin
      ring_len = int'(raw);
    end
    for (int k = 0; k < LANES; k++) begin
      lane_total[k] = 0;
      for (int i = 0; i < MAX_CELLS_DEF; i++) ring[k][i] = '0;
    end
    ring_pos = 0;
  endfunction

  // Apply one request to the predictor and return the means it produces.
  function automatic mean_t advance_window(input op_t op, input lane_t x, input lane_t y,
                                           input lane_t z);
    lane_t  s [LANES];
    longint q;
    lane_t  m [LANES];
    mean_t  r;
    s[0] = x;
    s[1] = y;
    s[2] = z;
    for (int k = 0; k < LANES; k++) begin
      if (op == OP_FILL) begin
        for (int i = 0; i < ring_len; i++) ring[k][i] = s[k];
        lane_total[k] = longint'(s[k]) * ring_len;
      end else begin
        lane_total[k] = lane_total[k] - longint'(ring[k][ring_pos]) + longint'(s[k]);
        ring[k][ring_pos] = s[k];
      end
    end
    if (op == OP_FILL) begin
      ring_pos = 0;
    end else begin
      ring_pos = (ring_pos + 1 >= ring_len) ? 0 : ring_pos + 1;
    end
    // Signed division truncates toward zero.
    for (int k = 0; k < LANES; k++) begin
      q = lane_total[k] / longint'(ring_len);
      m[k] = q[W-1:0];
    end
    r.x = m[0];
    r.y = m[1];
    r.z = m[2];
    return r;
  endfunction

  // Random sample value, weighted toward the extremes and small magnitudes.
  function automatic lane_t pick_sample();
    case ($urandom_range(9))
      0: return {1'b1, {(W-1){1'b0}}};
      1: return {1'b0, {(W-1){1'b1}}};
      2: return '0;
      3: return '1;
      4, 5: return lane_t'($signed($urandom_range(2000)) - 1000);
      default: return lane_t'($urandom);
    endcase
  endfunction

  // Random raw window length, including values that clamp.
  function automatic logic [CFG_BITS-1:0] pick_window();
    case ($urandom_range(9))
      0: return 1;
      1: return CFG_BITS'(MAX_CELLS_DEF);
      2: return 0;
      3: return '1;
      4: return CFG_BITS'($urandom_range(2047, MAX_CELLS_DEF + 1));
      5: return CFG_BITS'($urandom_range(MAX_CELLS_DEF - 1, 9));
      default: return CFG_BITS'($urandom_range(8, 2));
    endcase
  endfunction

  // Offer one request after a random idle gap (none when steady) and record its prediction.
  task automatic send_sample(input op_t op, input lane_t x, input lane_t y, input lane_t z);
    mean_t m;
    while (!steady && $urandom_range(99) < 37) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid    <= 1'b1;
    samples.mode     <= op;
    samples.sample_x <= x;
    samples.sample_y <= y;
    samples.sample_z <= z;
    do @(posedge clk); while (!samples.ready);
    m = advance_window(op, x, y, z);
    pending_means.push_back(m);
  endtask

  // Write the window length once every pending mean has come back.
  task automatic write_window(input logic [CFG_BITS-1:0] raw);
    samples.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= raw;
    @(posedge clk);
    cfg_write <= 1'b0;
    load_window(raw);
  endtask

  // Reset window of one: each mean equals its sample.
  task automatic test_reset_window();
    send_sample(OP_PUSH, {1'b0, {(W-1){1'b1}}}, {1'b1, {(W-1){1'b0}}}, '0);
    send_sample(OP_PUSH, {1'b1, {(W-1){1'b0}}}, '1, {1'b0, {(W-1){1'b1}}});
    send_sample(OP_PUSH, '0, {1'b0, {(W-1){1'b1}}}, '1);
    send_sample(OP_PUSH, '1, '0, {1'b1, {(W-1){1'b0}}});
    send_sample(OP_FILL, pick_sample(), pick_sample(), pick_sample());
  endtask

  // Zero maps to one, oversize values saturate; truncation toward zero.
  task automatic test_window_clamp();
    write_window(0);
    send_sample(OP_PUSH, -32'sd7, 32'sd7, {1'b1, {(W-1){1'b0}}});
    write_window('1);
    send_sample(OP_PUSH, -32'sd1, -32'sd1025, 32'sd1023);
    send_sample(OP_PUSH, -32'sd1023, 32'sd1, -32'sd1);
    write_window(CFG_BITS'(MAX_CELLS_DEF + 1));
    send_sample(OP_PUSH, 32'sd2048, -32'sd2049, {1'b0, {(W-1){1'b1}}});
  endtask

  // Fill the largest window with the extremes, then push over it.
  task automatic test_fill_full_window();
    write_window(CFG_BITS'(MAX_CELLS_DEF));
    send_sample(OP_FILL, {1'b1, {(W-1){1'b0}}}, {1'b0, {(W-1){1'b1}}}, '1);
    send_sample(OP_PUSH, {1'b0, {(W-1){1'b1}}}, {1'b1, {(W-1){1'b0}}}, '0);
  endtask

  // Small window: pushes wrap the ring, a fill resets the position.
  task automatic test_ring_wrap();
    write_window(3);
    for (int i = 0; i < 4; i++) begin
      send_sample(OP_PUSH, lane_t'(i * 3 - 5), lane_t'(-i * 100), lane_t'(i << 20));
    end
    send_sample(OP_FILL, -32'sd9, 32'sd9, 32'sd0);
    send_sample(OP_PUSH, 32'sd10, -32'sd10, -32'sd1);
  endtask

  // Long stretch with neither side idling.
  task automatic test_back_to_back();
    write_window(5);
    steady = 1'b1;
    repeat (40) begin
      send_sample(($urandom_range(9) == 0) ? OP_FILL : OP_PUSH,
                  pick_sample(), pick_sample(), pick_sample());
    end
    steady = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the input stalls.
  task automatic test_output_hold();
    write_window(4);
    hold_len = 400;
    hold_seq++;
    steady = 1'b1;
    repeat (12) send_sample(OP_PUSH, pick_sample(), pick_sample(), pick_sample());
    steady = 1'b0;
  endtask

  // Random windows, each followed by a run of random requests.
  task automatic test_random_windows();
    int sent;
    int n;
    sent = 0;
    while (sent < 470) begin
      write_window(pick_window());
      n = $urandom_range(60, 15);
      repeat (n) begin
        send_sample(($urandom_range(99) < 8) ? OP_FILL : OP_PUSH,
                    pick_sample(), pick_sample(), pick_sample());
      end
      sent += n;
    end
  endtask

  // Output ready: random stalls, no stalls when steady, long hold on request.
  initial begin
    means.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen  = hold_seq;
        stall_left = hold_len;
      end
      if (stall_left != 0) begin
        means.ready <= 1'b0;
        stall_left--;
      end else begin
        means.ready <= steady || ($urandom_range(99) >= 37);
      end
    end
  end

  // Compare each accepted mean with the oldest prediction.
  always @(posedge clk) begin
    mean_t exp_m;
    if (!rst && means.valid && means.ready) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected mean x=%0d y=%0d z=%0d", $time,
                 means.mean_x, means.mean_y, means.mean_z);
        mismatches++;
      end else begin
        exp_m = pending_means.pop_front();
        if (means.mean_x !== exp_m.x) begin
          $display("%0t: mean_x expected %0d actual %0d", $time, exp_m.x, means.mean_x);
          mismatches++;
        end
        if (means.mean_y !== exp_m.y) begin
          $display("%0t: mean_y expected %0d actual %0d", $time, exp_m.y, means.mean_y);
          mismatches++;
        end
        if (means.mean_z !== exp_m.z) begin
          $display("%0t: mean_z expected %0d actual %0d", $time, exp_m.z, means.mean_z);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, tests in turn, drain, verdict.
  initial begin
    samples.valid    <= 1'b0;
    samples.mode     <= OP_PUSH;
    samples.sample_x <= '0;
    samples.sample_y <= '0;
    samples.sample_z <= '0;
    cfg_write        <= 1'b0;
    cfg_data         <= '0;
    load_window(1);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_window();
    test_window_clamp();
    test_fill_full_window();
    test_ring_wrap();
    test_back_to_back();
    test_output_hold();
    test_random_windows();

    samples.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS vector_moving_average");
    end else begin
      $display("FAIL vector_moving_average");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #5ms;
    $display("FAIL vector_moving_average");
    $finish;
  end

endmodule
